// ----- sv/pipt_pkg.sv -----
// Shared constants, types and state codes for the point-in-polygon test unit.
`timescale 1ns / 1ps
`default_nettype none

package pipt_pkg;

    // Default sizes handed to the top level's parameters.
    localparam int MAX_VERTICES_DEF = 64;
    localparam int COORD_BITS_DEF   = 14;

    // Fixed field widths.
    localparam int IDX_BITS      = 6;
    localparam int VCOUNT_BITS   = 7;
    localparam int OUTER_BITS    = 15;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 15;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_VERTEX_COUNT = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_OUTER_X      = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_OUTER_Y      = 2'd2;

    // Configuration reset values.
    localparam logic [VCOUNT_BITS-1:0] VCOUNT_RST = 7'd3;
    localparam logic [OUTER_BITS-1:0]  OUTER_RST  = 15'h7FFF;

    // Request codes.
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Operations issued to the cross-product unit, one per step.
    localparam int STEP_BITS = 3;
    localparam logic [STEP_BITS-1:0] OP_EDGE_SIDE  = 3'd0; // side of point vs. edge
    localparam logic [STEP_BITS-1:0] OP_DOT        = 3'd1; // betweenness dot product
    localparam logic [STEP_BITS-1:0] OP_RAY_A      = 3'd2; // side of first end vs. ray
    localparam logic [STEP_BITS-1:0] OP_RAY_B      = 3'd3; // side of second end vs. ray
    localparam logic [STEP_BITS-1:0] OP_OUTER_SIDE = 3'd4; // side of outer point vs. edge
    localparam logic [STEP_BITS-1:0] XP_LATENCY    = 3'd3;
    localparam logic [STEP_BITS-1:0] STEP_LAST     = OP_OUTER_SIDE + XP_LATENCY;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RD_A,
        ST_RD_B,
        ST_CALC
    } t_state;

    typedef struct packed {
        logic neg;
        logic zero;
    } t_sign;

endpackage

`default_nettype wire

// ----- sv/point_in_polygon_test_unit.sv -----
// Top level of the point-in-polygon test unit: vertex store, edge sequencer and config.
`timescale 1ns / 1ps
`default_nettype none

// Usage notes.
// The unit holds a polygon of up to MAX_VERTICES vertices and answers whether a point
// lies inside it, by ray casting toward a configurable outer point. A point on any
// edge is reported as on the boundary and counts as inside.
// Items arrive as commands: a beat is accepted on a rising edge where start is high
// and busy is low. A load beat (i_req_type low) writes one vertex slot in that cycle,
// gives no result and leaves busy low; a slot at or beyond MAX_VERTICES is ignored.
// A query beat raises busy while the sequencer walks the edges. For each edge the
// two end points are read through the single read port of the vertex memory, and
// five sign tests are then issued to one shared cross-product unit, pipelined
// through difference, product and sign registers. The walk covers vertex_count
// edges, clamped to MAX_VERTICES, and ends early when the point is found on an
// edge; with a vertex count of zero there is no walk and the result follows in the
// cycle after acceptance. The result is shown on o_valid, o_inside_res and
// o_on_boundary for exactly one cycle, with busy low (just dropped after a walk);
// the receiver cannot stall it, so a new command may be accepted in that same cycle.
// The configuration channel (i_cfg_valid / o_cfg_ready) is always ready and should
// be written only while the unit is idle. Reset sets vertex_count to three and the
// outer point to (32767, 32767); the vertex memory is not cleared by reset.

module point_in_polygon_test_unit #(
    parameter int MAX_VERTICES = pipt_pkg::MAX_VERTICES_DEF,
    parameter int COORD_BITS   = pipt_pkg::COORD_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic                               i_req_type,
    input  wire logic [pipt_pkg::IDX_BITS-1:0]      i_vertex_index,
    input  wire logic [COORD_BITS-1:0]              i_vertex_x,
    input  wire logic [COORD_BITS-1:0]              i_vertex_y,
    input  wire logic [COORD_BITS-1:0]              i_point_x,
    input  wire logic [COORD_BITS-1:0]              i_point_y,
    output logic                                    o_valid,
    output logic                                    o_inside_res,
    output logic                                    o_on_boundary,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [pipt_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire logic [pipt_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int SW = (AW > pipt_pkg::IDX_BITS) ? AW : pipt_pkg::IDX_BITS;
    localparam int VW = (COORD_BITS > pipt_pkg::OUTER_BITS) ? COORD_BITS
                                                           : pipt_pkg::OUTER_BITS;

    // Configuration registers.
    logic [pipt_pkg::VCOUNT_BITS-1:0] r_vertex_count;
    logic [pipt_pkg::OUTER_BITS-1:0]  r_outer_x, r_outer_y;

    // Vertex memory with a registered read port.
    logic [COORD_BITS-1:0] r_vx_mem [MAX_VERTICES];
    logic [COORD_BITS-1:0] r_vy_mem [MAX_VERTICES];
    logic [COORD_BITS-1:0] r_rd_x, r_rd_y;

    // Sequencer state.
    pipt_pkg::t_state              r_state, n_state;
    logic [pipt_pkg::STEP_BITS-1:0] r_step, n_step;
    logic [AW-1:0]                 r_edge, n_edge;
    logic [CW-1:0]                 r_edge_count, n_edge_count;
    logic                          r_parity, n_parity;
    logic                          r_valid, n_valid;
    logic                          r_inside, n_inside;
    logic                          r_boundary, n_boundary;

    // Query payload and per-edge partial results.
    logic [COORD_BITS-1:0] r_px, r_py, r_ax, r_ay;
    pipt_pkg::t_sign       r_s_edge, r_s_ray_a, r_s_ray_b;
    logic                  r_dot_le;

    logic                  accept, do_load, do_query, slot_ok;
    logic [SW-1:0]         slot_ext;
    logic [CW-1:0]         sat_count, edge_plus;
    logic                  last_edge, on_edge, crossing;
    logic [AW-1:0]         next_vtx, rd_addr;
    pipt_pkg::t_sign       xp_sign;
    logic [VW-1:0]         ax, ay, bx, by, px, py, ox, oy;
    logic [VW-1:0]         ua, ub, va, vb, wa, wb, za, zb;

    assign accept   = start && !busy;
    assign do_load  = accept && (i_req_type == pipt_pkg::REQ_LOAD);
    assign do_query = accept && (i_req_type == pipt_pkg::REQ_QUERY);
    assign slot_ok  = int'(i_vertex_index) < MAX_VERTICES;
    assign slot_ext = SW'(i_vertex_index);

    // Counts beyond the memory depth are clamped to it.
    assign sat_count = (int'(r_vertex_count) > MAX_VERTICES) ? CW'(MAX_VERTICES)
                                                             : CW'(r_vertex_count);

    // The last edge closes back to vertex zero.
    assign edge_plus = CW'(r_edge) + CW'(1);
    assign last_edge = edge_plus >= r_edge_count;
    assign next_vtx  = last_edge ? '0 : edge_plus[AW-1:0];
    assign rd_addr   = (r_state == pipt_pkg::ST_RD_A) ? r_edge : next_vtx;

    always_ff @(posedge i_clk) begin
        if (do_load && slot_ok) begin
            r_vx_mem[slot_ext[AW-1:0]] <= i_vertex_x;
            r_vy_mem[slot_ext[AW-1:0]] <= i_vertex_y;
        end
        r_rd_x <= r_vx_mem[rd_addr];
        r_rd_y <= r_vy_mem[rd_addr];
    end

    // Operand selection for the shared unit. During the compute phase the read port
    // keeps addressing the second end point, so the read register holds it.
    assign ax = VW'(r_ax);
    assign ay = VW'(r_ay);
    assign bx = VW'(r_rd_x);
    assign by = VW'(r_rd_y);
    assign px = VW'(r_px);
    assign py = VW'(r_py);
    assign ox = VW'(r_outer_x);
    assign oy = VW'(r_outer_y);

    always_comb begin
        case (r_step)
            pipt_pkg::OP_DOT: begin
                // (a-p).(b-p) written as (ax-px)(bx-px) - (ay-py)(py-by).
                ua = ax; ub = px; va = bx; vb = px;
                wa = ay; wb = py; za = py; zb = by;
            end
            pipt_pkg::OP_RAY_A: begin
                ua = ox; ub = px; va = ay; vb = py;
                wa = oy; wb = py; za = ax; zb = px;
            end
            pipt_pkg::OP_RAY_B: begin
                ua = ox; ub = px; va = by; vb = py;
                wa = oy; wb = py; za = bx; zb = px;
            end
            pipt_pkg::OP_OUTER_SIDE: begin
                ua = bx; ub = ax; va = oy; vb = ay;
                wa = by; wb = ay; za = ox; zb = ax;
            end
            default: begin
                ua = bx; ub = ax; va = py; vb = ay;
                wa = by; wb = ay; za = px; zb = ax;
            end
        endcase
    end

    pipt_cross_unit #(
        .VW(VW)
    ) u_cross (
        .i_clk  (i_clk),
        .i_ua   (ua),
        .i_ub   (ub),
        .i_va   (va),
        .i_vb   (vb),
        .i_wa   (wa),
        .i_wb   (wb),
        .i_za   (za),
        .i_zb   (zb),
        .o_sign (xp_sign)
    );

    // Edge decision at the last step, when the outer-point side is coming out of the unit.
    assign on_edge  = r_s_edge.zero && r_dot_le;
    assign crossing = !r_s_ray_a.zero && !r_s_ray_b.zero
                   && (r_s_ray_a.neg != r_s_ray_b.neg)
                   && !r_s_edge.zero && !xp_sign.zero
                   && (r_s_edge.neg != xp_sign.neg);

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (do_query) begin
            r_px <= i_point_x;
            r_py <= i_point_y;
        end
        if (r_state == pipt_pkg::ST_RD_B) begin
            r_ax <= r_rd_x;
            r_ay <= r_rd_y;
        end
        if (r_state == pipt_pkg::ST_CALC) begin
            if (r_step == pipt_pkg::OP_EDGE_SIDE + pipt_pkg::XP_LATENCY) begin
                r_s_edge <= xp_sign;
            end
            if (r_step == pipt_pkg::OP_DOT + pipt_pkg::XP_LATENCY) begin
                r_dot_le <= xp_sign.neg || xp_sign.zero;
            end
            if (r_step == pipt_pkg::OP_RAY_A + pipt_pkg::XP_LATENCY) begin
                r_s_ray_a <= xp_sign;
            end
            if (r_step == pipt_pkg::OP_RAY_B + pipt_pkg::XP_LATENCY) begin
                r_s_ray_b <= xp_sign;
            end
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= pipt_pkg::VCOUNT_RST;
            r_outer_x      <= pipt_pkg::OUTER_RST;
            r_outer_y      <= pipt_pkg::OUTER_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                pipt_pkg::CFG_VERTEX_COUNT: begin
                    r_vertex_count <= i_cfg_data[pipt_pkg::VCOUNT_BITS-1:0];
                end
                pipt_pkg::CFG_OUTER_X: begin
                    r_outer_x <= i_cfg_data;
                end
                pipt_pkg::CFG_OUTER_Y: begin
                    r_outer_y <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= pipt_pkg::ST_IDLE;
            r_step       <= '0;
            r_edge       <= '0;
            r_edge_count <= '0;
            r_parity     <= 1'b0;
            r_valid      <= 1'b0;
            r_inside     <= 1'b0;
            r_boundary   <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_step       <= n_step;
            r_edge       <= n_edge;
            r_edge_count <= n_edge_count;
            r_parity     <= n_parity;
            r_valid      <= n_valid;
            r_inside     <= n_inside;
            r_boundary   <= n_boundary;
        end
    end

    // Next state and result.
    always_comb begin
        n_state      = r_state;
        n_step       = r_step;
        n_edge       = r_edge;
        n_edge_count = r_edge_count;
        n_parity     = r_parity;
        n_valid      = 1'b0;
        n_inside     = r_inside;
        n_boundary   = r_boundary;
        case (r_state)
            pipt_pkg::ST_IDLE: begin
                if (do_query) begin
                    n_edge       = '0;
                    n_edge_count = sat_count;
                    n_parity     = 1'b0;
                    if (sat_count == '0) begin
                        // No edges: the point is outside.
                        n_valid    = 1'b1;
                        n_inside   = 1'b0;
                        n_boundary = 1'b0;
                    end else begin
                        n_state = pipt_pkg::ST_RD_A;
                    end
                end
            end
            pipt_pkg::ST_RD_A: begin
                n_state = pipt_pkg::ST_RD_B;
            end
            pipt_pkg::ST_RD_B: begin
                n_state = pipt_pkg::ST_CALC;
                n_step  = '0;
            end
            pipt_pkg::ST_CALC: begin
                n_step = r_step + 1'b1;
                if (r_step == pipt_pkg::STEP_LAST) begin
                    if (on_edge) begin
                        n_valid    = 1'b1;
                        n_inside   = 1'b1;
                        n_boundary = 1'b1;
                        n_parity   = 1'b0;
                        n_edge     = '0;
                        n_state    = pipt_pkg::ST_IDLE;
                    end else if (last_edge) begin
                        n_valid    = 1'b1;
                        n_inside   = r_parity ^ crossing;
                        n_boundary = 1'b0;
                        n_parity   = r_parity ^ crossing;
                        n_edge     = '0;
                        n_state    = pipt_pkg::ST_IDLE;
                    end else begin
                        n_parity = r_parity ^ crossing;
                        n_edge   = edge_plus[AW-1:0];
                        n_state  = pipt_pkg::ST_RD_A;
                    end
                end
            end
            default: begin
                n_state = pipt_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy          = (r_state != pipt_pkg::ST_IDLE);
    assign o_valid       = r_valid;
    assign o_inside_res  = r_inside;
    assign o_on_boundary = r_boundary;
    assign o_cfg_ready   = 1'b1;

endmodule

`default_nettype wire

// ----- sv/pipt_cross_unit.sv -----
// Shared pipelined unit that returns the sign of (ua-ub)*(va-vb) - (wa-wb)*(za-zb).
`timescale 1ns / 1ps
`default_nettype none

module pipt_cross_unit #(
    parameter int VW = 15
) (
    input  wire logic              i_clk,
    input  wire logic [VW-1:0]     i_ua,
    input  wire logic [VW-1:0]     i_ub,
    input  wire logic [VW-1:0]     i_va,
    input  wire logic [VW-1:0]     i_vb,
    input  wire logic [VW-1:0]     i_wa,
    input  wire logic [VW-1:0]     i_wb,
    input  wire logic [VW-1:0]     i_za,
    input  wire logic [VW-1:0]     i_zb,
    output pipt_pkg::t_sign        o_sign
);

    localparam int DW = VW + 1;

    logic signed [DW-1:0]   r_u, r_v, r_w, r_z;
    logic signed [2*DW-1:0] r_p1, r_p2;
    logic        [2*DW:0]   diff;
    pipt_pkg::t_sign        r_sign;

    // Three stages: differences, products, then the sign of their difference.
    always_ff @(posedge i_clk) begin
        r_u    <= $signed({1'b0, i_ua}) - $signed({1'b0, i_ub});
        r_v    <= $signed({1'b0, i_va}) - $signed({1'b0, i_vb});
        r_w    <= $signed({1'b0, i_wa}) - $signed({1'b0, i_wb});
        r_z    <= $signed({1'b0, i_za}) - $signed({1'b0, i_zb});
        r_p1   <= r_u * r_v;
        r_p2   <= r_w * r_z;
        r_sign <= '{neg: diff[2*DW], zero: (diff == '0)};
    end

    assign diff   = {r_p1[2*DW-1], r_p1} - {r_p2[2*DW-1], r_p2};
    assign o_sign = r_sign;

endmodule

`default_nettype wire

// ----- sv/pipt_checker.sv -----
// Port-level checker for the point-in-polygon test unit and its bind.
`timescale 1ns / 1ps
`default_nettype none

module pipt_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic i_req_type,
    input wire logic o_valid,
    input wire logic o_inside_res,
    input wire logic o_on_boundary
);

    // A result only follows a query walk or a query accepted in the cycle before.
    a_result_from_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(busy)
                  || $past(start && !busy && (i_req_type == pipt_pkg::REQ_QUERY))))
        else $error("result beat without a query");

    // A load beat neither starts a walk nor produces a result.
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_req_type == pipt_pkg::REQ_LOAD)) |=> (!busy && !o_valid))
        else $error("load beat caused busy or a result");

    // A query beat leads either to a walk or to an immediate result, never both.
    a_query_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_req_type == pipt_pkg::REQ_QUERY))
            |=> ($countones({busy, o_valid}) == 1))
        else $error("query beat not followed by exactly one of busy or result");

    // The end of a walk is marked by a result beat. Busy must have been seen high,
    // so the unknown value before the first reset edge does not count as a fall.
    a_walk_ends_in_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!busy && $past(busy)) |-> o_valid)
        else $error("walk finished without a result beat");

    // A boundary point counts as inside.
    a_boundary_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_on_boundary) |-> o_inside_res)
        else $error("boundary result not flagged inside");

endmodule

bind point_in_polygon_test_unit pipt_checker u_pipt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .i_req_type    (i_req_type),
    .o_valid       (o_valid),
    .o_inside_res  (o_inside_res),
    .o_on_boundary (o_on_boundary)
);

`default_nettype wire

// ----- tb/sv/point_in_polygon_test_unit_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the point-in-polygon test unit, with its own ray-casting predictor.
module point_in_polygon_test_unit_test;
    import pipt_pkg::*;

    localparam int NV           = MAX_VERTICES_DEF;
    localparam int CB           = COORD_BITS_DEF;
    localparam int COORD_MAX    = (1 << CB) - 1;
    localparam int OUTER_MAX    = (1 << OUTER_BITS) - 1;
    localparam int RANDOM_ITEMS = 1600;
    // The slowest query walks every edge of a full store. Even if every item were
    // such a query plus the longest sender gap, the run would stay several times below this limit.
    localparam int CYCLE_LIMIT  = 8_000_000;
    localparam int DRAIN_LIMIT  = 4000;
    // Index 3 decodes to no register. Writing it must leave the others alone.
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = 2'd3;

    typedef logic [CB-1:0] t_coord;

    typedef struct packed {
        logic inside_res;
        logic on_boundary;
    } t_verdict;

    typedef struct packed {
        logic                req_type;
        logic [IDX_BITS-1:0] idx;
        t_coord              vx;
        t_coord              vy;
        t_coord              px;
        t_coord              py;
    } t_pip_item;

    // Clock and DUT signals.
    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     start;
    logic                     busy;
    logic                     i_req_type;
    logic [IDX_BITS-1:0]      i_vertex_index;
    t_coord                   i_vertex_x;
    t_coord                   i_vertex_y;
    t_coord                   i_point_x;
    t_coord                   i_point_y;
    logic                     o_valid;
    logic                     o_inside_res;
    logic                     o_on_boundary;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;

    // The testbench keeps its own copy of the polygon and of the registers.
    t_coord                  shadow_x [NV];
    t_coord                  shadow_y [NV];
    logic [VCOUNT_BITS-1:0]  cfg_count;
    logic [OUTER_BITS-1:0]   cfg_outer_x;
    logic [OUTER_BITS-1:0]   cfg_outer_y;

    // Verdicts predicted for accepted queries, oldest first.
    t_verdict pending_verdicts [$];

    int          errors;
    int          items_sent;
    int          loads_sent;
    int          queries_sent;
    int          inside_seen;
    int          boundary_seen;
    int          phases_run;
    int unsigned cycle_count;
    bit          idle_en;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    point_in_polygon_test_unit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_req_type     (i_req_type),
        .i_vertex_index (i_vertex_index),
        .i_vertex_x     (i_vertex_x),
        .i_vertex_y     (i_vertex_y),
        .i_point_x      (i_point_x),
        .i_point_y      (i_point_y),
        .o_valid        (o_valid),
        .o_inside_res   (o_inside_res),
        .o_on_boundary  (o_on_boundary),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // Sign of the cross product (b - a) x (c - a). With coordinates below
    // 2^15, 64-bit arithmetic cannot overflow.
    function automatic int side_of(longint ax, longint ay, longint bx, longint by,
                                   longint cx, longint cy);
        longint v;
        v = (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
        return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    // Predicts the verdict for one query against the shadow polygon. The walk
    // covers every edge and closes the last vertex back to slot 0. A point on an
    // edge ends the walk at once. Otherwise each strict crossing of the ray
    // segment toward the outer point flips the parity.
    function automatic t_verdict locate_point(t_coord qx, t_coord qy);
        int       n;
        int       j;
        longint   px, py, ox, oy, ax, ay, bx, by;
        bit       parity;
        t_verdict v;
        n      = (cfg_count > NV) ? NV : int'(cfg_count);
        px     = longint'(qx);
        py     = longint'(qy);
        ox     = longint'(cfg_outer_x);
        oy     = longint'(cfg_outer_y);
        parity = 1'b0;
        for (int i = 0; i < n; i++) begin
            j  = (i + 1 >= n) ? 0 : i + 1;
            ax = longint'(shadow_x[i]);
            ay = longint'(shadow_y[i]);
            bx = longint'(shadow_x[j]);
            by = longint'(shadow_y[j]);
            if (side_of(ax, ay, bx, by, px, py) == 0 &&
                (ax - px) * (bx - px) + (ay - py) * (by - py) <= 0) begin
                v.inside_res  = 1'b1;
                v.on_boundary = 1'b1;
                return v;
            end
            if (side_of(px, py, ox, oy, ax, ay) * side_of(px, py, ox, oy, bx, by) < 0 &&
                side_of(ax, ay, bx, by, px, py) * side_of(ax, ay, bx, by, ox, oy) < 0)
                parity = ~parity;
        end
        v.inside_res  = parity;
        v.on_boundary = 1'b0;
        return v;
    endfunction

    function automatic int gcd_of(int a, int b);
        int t;
        while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    // Sends one command beat. The beat is driven at a rising edge and is held
    // until busy is seen low at the falling edge before a rising edge, so it is
    // accepted at that edge. The prediction is made at the accepting edge itself. The
    // checker samples at falling edges, so the two never meet in one time step.
    task automatic send_item(input t_pip_item it);
        if (idle_en && $urandom_range(0, 99) < 11) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_req_type     <= it.req_type;
        i_vertex_index <= it.idx;
        i_vertex_x     <= it.vx;
        i_vertex_y     <= it.vy;
        i_point_x      <= it.px;
        i_point_y      <= it.py;
        do @(negedge i_clk); while (busy);
        @(posedge i_clk);
        items_sent++;
        if (it.req_type == REQ_LOAD) begin
            shadow_x[it.idx] = it.vx;
            shadow_y[it.idx] = it.vy;
            loads_sent++;
        end else begin
            pending_verdicts.insert(pending_verdicts.size(), locate_point(it.px, it.py));
            queries_sent++;
        end
    endtask

    // The fields that a beat does not use carry random values, so that every
    // bit of every port toggles.
    task automatic load_vertex(input int slot, input int x, input int y);
        t_pip_item it;
        it.req_type = REQ_LOAD;
        it.idx      = slot[IDX_BITS-1:0];
        it.vx       = x[CB-1:0];
        it.vy       = y[CB-1:0];
        it.px       = t_coord'($urandom_range(0, COORD_MAX));
        it.py       = t_coord'($urandom_range(0, COORD_MAX));
        send_item(it);
    endtask

    task automatic query_point(input int x, input int y);
        t_pip_item it;
        it.req_type = REQ_QUERY;
        it.idx      = IDX_BITS'($urandom_range(0, NV - 1));
        it.vx       = t_coord'($urandom_range(0, COORD_MAX));
        it.vy       = t_coord'($urandom_range(0, COORD_MAX));
        it.px       = x[CB-1:0];
        it.py       = y[CB-1:0];
        send_item(it);
    endtask

    // Lowers start and waits for every outstanding query verdict. A load
    // finishes in the cycle in which it is accepted, so loads need no waiting
    // of their own before the registers are touched.
    task automatic wait_idle();
        start <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // One beat on the register channel. The write begins on a fresh edge, so
    // valid is never lowered and raised again in the same time step.
    task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        @(posedge i_clk);
        if (idle_en && $urandom_range(0, 99) < 11)
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(negedge i_clk); while (!o_cfg_ready);
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_VERTEX_COUNT: cfg_count   = data[VCOUNT_BITS-1:0];
            CFG_OUTER_X:      cfg_outer_x = data[OUTER_BITS-1:0];
            CFG_OUTER_Y:      cfg_outer_y = data[OUTER_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(input int count_data, input int ox, input int oy);
        wait_idle();
        cfg_write(CFG_VERTEX_COUNT, count_data[CFG_DATA_BITS-1:0]);
        cfg_write(CFG_OUTER_X, ox[CFG_DATA_BITS-1:0]);
        cfg_write(CFG_OUTER_Y, oy[CFG_DATA_BITS-1:0]);
    endtask

    // All 64 slots get a value before any query, so that no query can read a
    // slot that was never written.
    task automatic test_vertex_setup();
        for (int s = 0; s < NV; s++)
            load_vertex(s, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
    endtask

    // A triangle at the corners of the coordinate range, checked under the
    // register values left by reset.
    task automatic test_reset_defaults();
        load_vertex(0, 0, 0);
        load_vertex(1, COORD_MAX, 0);
        load_vertex(2, 0, COORD_MAX);
        query_point(100, 100);
        query_point(0, 0);
        query_point(COORD_MAX / 2, COORD_MAX / 2 + 1);
        query_point(COORD_MAX, COORD_MAX);
        query_point(COORD_MAX, 0);
        query_point(0, 5000);
    endtask

    // A square, with rays that pass exactly through a corner or run along a side,
    // neither of which counts as a crossing, plus a plain crossing and a point on a side.
    task automatic test_ray_touches();
        configure(4, 4000, 4000);
        load_vertex(0, 1000, 1000);
        load_vertex(1, 3000, 1000);
        load_vertex(2, 3000, 3000);
        load_vertex(3, 1000, 3000);
        query_point(2000, 2000);
        query_point(2000, 1500);
        configure(4, 4000, 1000);
        query_point(500, 1000);
        query_point(2000, 1000);
    endtask

    // A count of zero has no edges. Counts of one and two walk degenerate edges.
    task automatic test_small_counts();
        for (int c = 0; c < 3; c++) begin
            configure(c, OUTER_MAX, OUTER_MAX);
            query_point(1000, 1000);
            query_point(2000, 1000);
        end
    endtask

    // A count above the store depth is clipped to the depth. A write with all
    // data bits set also shows that the upper data bits are dropped. A write to the spare index follows.
    task automatic test_saturated_count();
        configure({CFG_DATA_BITS{1'b1}}, OUTER_MAX, OUTER_MAX);
        query_point(int'(shadow_x[NV-1]), int'(shadow_y[NV-1]));
        query_point($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
        configure(NV, OUTER_MAX, OUTER_MAX);
        wait_idle();
        cfg_write(CFG_SPARE, CFG_DATA_BITS'($urandom_range(0, OUTER_MAX)));
        query_point(8000, 8000);
    endtask

    // The outer point at the other corners of its range.
    task automatic test_outer_extremes();
        configure(4, 0, 0);
        load_vertex(0, 1000, 1000);
        load_vertex(1, 3000, 1000);
        load_vertex(2, 3000, 3000);
        load_vertex(3, 1000, 3000);
        query_point(2000, 2000);
        configure(4, 0, OUTER_MAX);
        query_point(1500, 2500);
        configure(4, OUTER_MAX, 0);
        query_point(2500, 1500);
        query_point(500, 500);
    endtask

    // Random phases. Each phase sets the registers while the unit is idle, loads
    // a polygon of one of three layouts, and queries points. Most points are
    // picked on vertices, on edges or near the polygon. Random loads are mixed
    // in between queries, and now and then a phase skips the polygon load and
    // queries the polygon left by earlier phases.
    task automatic test_random_phases();
        int target;
        int r;
        int count;
        int n_eff;
        int nq;
        int layout;
        int pitch;
        int org_x, org_y;
        int ox, oy;
        int x, y;
        int i, j, dx, dy, g, t;
        int lo_x, hi_x, lo_y, hi_y;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) begin
            // A long stretch of phases runs with no idling at all.
            idle_en = !(phases_run >= 20 && phases_run < 32);

            r = $urandom_range(0, 99);
            if (r < 5)
                count = $urandom_range(0, 2);
            else if (r < 11)
                count = $urandom_range(0, 1) ? NV : $urandom_range(NV + 1, 127);
            else
                count = $urandom_range(3, 12);
            n_eff = (count > NV) ? NV : count;

            r = $urandom_range(0, 99);
            if (r < 50) begin
                ox = OUTER_MAX;
                oy = OUTER_MAX;
            end else if (r < 75) begin
                ox = $urandom_range(COORD_MAX + 1, OUTER_MAX);
                oy = $urandom_range(COORD_MAX + 1, OUTER_MAX);
            end else if (r < 90) begin
                ox = $urandom_range(0, OUTER_MAX);
                oy = $urandom_range(0, OUTER_MAX);
            end else begin
                ox = $urandom_range(0, 1) ? OUTER_MAX : 0;
                oy = $urandom_range(0, 1) ? OUTER_MAX : 0;
            end
            configure(($urandom_range(0, 255) << VCOUNT_BITS) | count, ox, oy);

            if ($urandom_range(0, 9) != 0) begin
                layout = $urandom_range(0, 2);
                pitch  = $urandom_range(1, 2047);
                org_x  = $urandom_range(0, COORD_MAX - 7 * pitch);
                org_y  = $urandom_range(0, COORD_MAX - 7 * pitch);
                for (int s = 0; s < n_eff; s++) begin
                    case (layout)
                        0: begin
                            x = $urandom_range(0, COORD_MAX);
                            y = $urandom_range(0, COORD_MAX);
                        end
                        1: begin
                            x = org_x + $urandom_range(0, 7) * pitch;
                            y = org_y + $urandom_range(0, 7) * pitch;
                        end
                        default: begin
                            x = $urandom_range(0, 31);
                            y = $urandom_range(0, 31);
                        end
                    endcase
                    load_vertex(s, x, y);
                end
            end

            lo_x = COORD_MAX;
            hi_x = 0;
            lo_y = COORD_MAX;
            hi_y = 0;
            for (int s = 0; s < n_eff; s++) begin
                if (int'(shadow_x[s]) < lo_x) lo_x = int'(shadow_x[s]);
                if (int'(shadow_x[s]) > hi_x) hi_x = int'(shadow_x[s]);
                if (int'(shadow_y[s]) < lo_y) lo_y = int'(shadow_y[s]);
                if (int'(shadow_y[s]) > hi_y) hi_y = int'(shadow_y[s]);
            end
            lo_x = (lo_x < 2) ? 0 : lo_x - 2;
            lo_y = (lo_y < 2) ? 0 : lo_y - 2;
            hi_x = (hi_x > COORD_MAX - 2) ? COORD_MAX : hi_x + 2;
            hi_y = (hi_y > COORD_MAX - 2) ? COORD_MAX : hi_y + 2;

            nq = (n_eff > 16) ? $urandom_range(2, 4) : $urandom_range(6, 16);
            for (int q = 0; q < nq; q++) begin
                if (phases_run == 7 && q == nq / 2)
                    wait_idle();
                r = $urandom_range(0, 99);
                if (r < 8) begin
                    load_vertex($urandom_range(0, NV - 1), $urandom_range(0, COORD_MAX),
                                $urandom_range(0, COORD_MAX));
                end else if (n_eff == 0 || r < 18) begin
                    query_point($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
                end else if (r < 40) begin
                    i = $urandom_range(0, n_eff - 1);
                    query_point(int'(shadow_x[i]), int'(shadow_y[i]));
                end else if (r < 62) begin
                    // A lattice point on the edge, picked so that it lies
                    // exactly on the segment.
                    i  = $urandom_range(0, n_eff - 1);
                    j  = (i + 1 >= n_eff) ? 0 : i + 1;
                    dx = int'(shadow_x[j]) - int'(shadow_x[i]);
                    dy = int'(shadow_y[j]) - int'(shadow_y[i]);
                    g  = gcd_of((dx < 0) ? -dx : dx, (dy < 0) ? -dy : dy);
                    t  = (g == 0) ? 0 : $urandom_range(0, g);
                    if (g == 0)
                        query_point(int'(shadow_x[i]), int'(shadow_y[i]));
                    else
                        query_point(int'(shadow_x[i]) + dx / g * t,
                                    int'(shadow_y[i]) + dy / g * t);
                end else begin
                    query_point($urandom_range(lo_x, hi_x), $urandom_range(lo_y, hi_y));
                end
            end
            phases_run++;
        end
        idle_en = 1'b1;
    endtask

    // Checks each result in the one cycle in which it is shown. Sampling at
    // the falling edge keeps it clear of the drive edge.
    always @(negedge i_clk) begin
        t_verdict want;
        if (i_rst_n && o_valid) begin
            if (pending_verdicts.size() == 0) begin
                $error("result with no query waiting: inside_res=%0b on_boundary=%0b",
                       o_inside_res, o_on_boundary);
                errors++;
            end else begin
                want = pending_verdicts.pop_front();
                if (o_inside_res !== want.inside_res) begin
                    $error("inside_res mismatch: expected %0b, actual %0b",
                           want.inside_res, o_inside_res);
                    errors++;
                end
                if (o_on_boundary !== want.on_boundary) begin
                    $error("on_boundary mismatch: expected %0b, actual %0b",
                           want.on_boundary, o_on_boundary);
                    errors++;
                end
                if (want.inside_res) inside_seen++;
                if (want.on_boundary) boundary_seen++;
            end
        end
    end

    // Ends a run that hangs.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles with %0d verdicts outstanding.",
                 cycle_count, pending_verdicts.size());
        $display("Some tests failed");
        $finish;
    end

    initial begin
        i_rst_n        <= 1'b0;
        start          <= 1'b0;
        i_req_type     <= REQ_LOAD;
        i_vertex_index <= '0;
        i_vertex_x     <= '0;
        i_vertex_y     <= '0;
        i_point_x      <= '0;
        i_point_y      <= '0;
        i_cfg_valid    <= 1'b0;
        i_cfg_index    <= CFG_VERTEX_COUNT;
        i_cfg_data     <= '0;
        cfg_count      = VCOUNT_RST;
        cfg_outer_x    = OUTER_RST;
        cfg_outer_y    = OUTER_RST;
        errors         = 0;
        items_sent     = 0;
        loads_sent     = 0;
        queries_sent   = 0;
        inside_seen    = 0;
        boundary_seen  = 0;
        phases_run     = 0;
        idle_en        = 1'b1;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_vertex_setup();
        test_reset_defaults();
        test_ray_touches();
        test_small_counts();
        test_saturated_count();
        test_outer_extremes();
        test_random_phases();

        start <= 1'b0;
        for (int k = 0; k < DRAIN_LIMIT && pending_verdicts.size() != 0; k++)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (pending_verdicts.size() != 0) begin
            $error("%0d query verdicts never arrived", pending_verdicts.size());
            errors++;
        end

        $display("Ran %0d vertex loads and %0d queries, %0d random phases, in %0d cycles.",
                 loads_sent, queries_sent, phases_run, cycle_count);
        $display("Queries found %0d points inside, %0d of them on an edge; %0d errors.",
                 inside_seen, boundary_seen, errors);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
